/* rtl/rgbyg_pkg.sv */
// Shared constants, codes and helpers for the RGB/YUV gray and luma-shift block.
package rgbyg_pkg;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned DELTA_W = 17;
	localparam int unsigned WDATA_W = 17;

	// Register indexes on the configuration port
	typedef enum logic [0:0] {
		REG_MODE  = 1'b0,
		REG_DELTA = 1'b1
	} reg_idx_t;

	// Output mode codes
	typedef enum logic [0:0] {
		MODE_GRAY  = 1'b0,
		MODE_SHIFT = 1'b1
	} mode_t;

	// Forward transform, 16 fraction bits (magnitudes, signs applied in the sums)
	localparam logic [15:0] C_YR = 16'd19595;
	localparam logic [15:0] C_YG = 16'd38470;
	localparam logic [15:0] C_YB = 16'd7471;
	localparam logic [15:0] C_UR = 16'd9634;
	localparam logic [15:0] C_UG = 16'd18940;
	localparam logic [15:0] C_UB = 16'd28574;
	localparam logic [15:0] C_VR = 16'd40305;
	localparam logic [15:0] C_VG = 16'd33751;
	localparam logic [15:0] C_VB = 16'd6554;

	// Inverse transform, 16 fraction bits, signed operands for the multipliers
	localparam logic signed [18:0] C_RV = 19'sd74646;
	localparam logic signed [18:0] C_GU = 19'sd25887;
	localparam logic signed [18:0] C_GV = 19'sd38076;
	localparam logic signed [18:0] C_BU = 19'sd133169;

	// Saturate a signed integer channel to 0..255
	function automatic logic [PIX_W-1:0] clamp8(input logic signed [13:0] val);
		logic [PIX_W-1:0] res;
		if (val < 0) begin
			res = '0;
		end else if (val > 14'sd255) begin
			res = 8'd255;
		end else begin
			res = val[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/rgbyg_if.sv */
// Stream interfaces: input pixel channel and result pixel channel.
interface rgbyg_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rgbyg_pkg::PIX_W-1:0] red;
	logic [rgbyg_pkg::PIX_W-1:0] green;
	logic [rgbyg_pkg::PIX_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbyg_res_if;
	logic                        valid;
	logic                        ready;
	logic [rgbyg_pkg::PIX_W-1:0] red_out;
	logic [rgbyg_pkg::PIX_W-1:0] green_out;
	logic [rgbyg_pkg::PIX_W-1:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface

/* rtl/rgb_yuv_gray_and_luma_shift_top.sv */
// RGB to YUV gray / luma-shift pixel pipeline, top level.
//
// Usage:
//   pixel  : input words (red, green, blue), valid/ready, taken when both high.
//   result : output words (red_out, green_out, blue_out), valid/ready.
//   wr_en/wr_index/wr_data : register writes, one per clock, no read-back.
//     index 0 = mode (0 gray, 1 luma shift), index 1 = delta_y (Q9.8 signed).
//     Write only while the pipe is empty; mode is taken with the word at
//     accept, delta_y is read live when the word moves into s2.
// Stages s1..s4 lie between accept and result valid:
//   s1 forward-transform products, s2 Y/U/V sums plus delta,
//   s3 inverse-transform products, s4 channel sums, floor, clamp (output reg).
// Throughput: one word per clock while result.ready holds; each stage holds one word and the constant
//   multipliers of s1 (nine) and s3 (four) are per stage, so nothing is shared.
// Stall: each stage advances when it is empty or the next one advances, so
//   a stalled result holds in s4 while bubbles upstream still fill; pixel.ready
//   drops only once all four stages hold words.
// Reset: arst_n clears stage valids and both registers (gray mode, zero delta).
module rgb_yuv_gray_and_luma_shift_top (
	input  logic                            clk,
	input  logic                            arst_n,
	rgbyg_pix_if.sink                       pixel,
	rgbyg_res_if.source                     result,
	input  logic                            wr_en,
	input  logic                            wr_index,
	input  logic [rgbyg_pkg::WDATA_W-1:0]   wr_data
);

	// ---------------- configuration registers ----------------
	logic                                 mode_q;
	logic signed [rgbyg_pkg::DELTA_W-1:0] delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= rgbyg_pkg::MODE_GRAY;
			delta_q <= '0;
		end else if (wr_en) begin
			case (rgbyg_pkg::reg_idx_t'(wr_index))
				rgbyg_pkg::REG_MODE:  mode_q  <= wr_data[0];
				rgbyg_pkg::REG_DELTA: delta_q <= wr_data[rgbyg_pkg::DELTA_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage advance chain ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4 = !vld_s4 || result.ready;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign pixel.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= pixel.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
		end
	end

	// ---------------- s1: forward products ----------------
	logic [23:0] yr_s1, yg_s1, yb_s1, ur_s1, ug_s1, ub_s1, vr_s1, vg_s1, vb_s1;
	logic        mode_s1;

	always_ff @(posedge clk) begin
		if (adv1 && pixel.valid) begin
			yr_s1   <= pixel.red   * rgbyg_pkg::C_YR;
			yg_s1   <= pixel.green * rgbyg_pkg::C_YG;
			yb_s1   <= pixel.blue  * rgbyg_pkg::C_YB;
			ur_s1   <= pixel.red   * rgbyg_pkg::C_UR;
			ug_s1   <= pixel.green * rgbyg_pkg::C_UG;
			ub_s1   <= pixel.blue  * rgbyg_pkg::C_UB;
			vr_s1   <= pixel.red   * rgbyg_pkg::C_VR;
			vg_s1   <= pixel.green * rgbyg_pkg::C_VG;
			vb_s1   <= pixel.blue  * rgbyg_pkg::C_VB;
			mode_s1 <= mode_q;
		end
	end

	// ---------------- s2: Y/U/V sums, luma offset ----------------
	logic [23:0]        y_c;
	logic signed [25:0] u_c, v_c;
	logic signed [26:0] ys_c;

	assign y_c  = yr_s1 + yg_s1 + yb_s1;         // exact, max 255 << 16
	assign u_c  = 26'(ub_s1) - 26'(ur_s1) - 26'(ug_s1);
	assign v_c  = 26'(vr_s1) - 26'(vg_s1) - 26'(vb_s1);
	// delta is Q9.8, move to 16 fraction bits
	assign ys_c = 27'(y_c) + {{2{delta_q[rgbyg_pkg::DELTA_W-1]}}, delta_q, 8'b0};

	logic signed [26:0] ys_s2;
	logic signed [25:0] u_s2, v_s2;
	logic [7:0]         gray_s2;
	logic               mode_s2;

	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			ys_s2   <= ys_c;
			u_s2    <= u_c;
			v_s2    <= v_c;
			gray_s2 <= y_c[23:16];
			mode_s2 <= mode_s1;
		end
	end

	// ---------------- s3: inverse products ----------------
	logic signed [45:0] rv_s3, gu_s3, gv_s3, bu_s3;
	logic signed [26:0] ys_s3;
	logic [7:0]         gray_s3;
	logic               mode_s3;

	always_ff @(posedge clk) begin
		if (adv3 && vld_s2) begin
			rv_s3   <= v_s2 * rgbyg_pkg::C_RV;
			gu_s3   <= u_s2 * rgbyg_pkg::C_GU;
			gv_s3   <= v_s2 * rgbyg_pkg::C_GV;
			bu_s3   <= u_s2 * rgbyg_pkg::C_BU;
			ys_s3   <= ys_s2;
			gray_s3 <= gray_s2;
			mode_s3 <= mode_s2;
		end
	end

	// ---------------- s4: channel sums, floor, clamp ----------------
	logic signed [45:0] yw_c, ro_c, go_c, bo_c;
	logic [7:0]         r_c, g_c, b_c;

	assign yw_c = {{3{ys_s3[26]}}, ys_s3, 16'b0};
	assign ro_c = yw_c + rv_s3;
	assign go_c = yw_c - gu_s3 - gv_s3;
	assign bo_c = yw_c + bu_s3;

	// bits [45:32] of an exact sum are its floor at 32 fraction bits
	always_comb begin
		if (mode_s3 == rgbyg_pkg::MODE_GRAY) begin
			r_c = gray_s3;
			g_c = gray_s3;
			b_c = gray_s3;
		end else begin
			r_c = rgbyg_pkg::clamp8(ro_c[45:32]);
			g_c = rgbyg_pkg::clamp8(go_c[45:32]);
			b_c = rgbyg_pkg::clamp8(bo_c[45:32]);
		end
	end

	logic [7:0] red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (adv4 && vld_s3) begin
			red_s4   <= r_c;
			green_s4 <= g_c;
			blue_s4  <= b_c;
		end
	end

	assign result.valid     = vld_s4;
	assign result.red_out   = red_s4;
	assign result.green_out = green_s4;
	assign result.blue_out  = blue_s4;

endmodule

/* rtl/rgbyg_check.sv */
// Port-level checker for the gray / luma-shift pipeline, bound to the top level.
module rgbyg_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rgbyg_pkg::PIX_W-1:0]   red_out,
	input logic [rgbyg_pkg::PIX_W-1:0]   green_out,
	input logic [rgbyg_pkg::PIX_W-1:0]   blue_out,
	input logic                          wr_en,
	input logic                          wr_index,
	input logic                          wr_mode_bit
);

	// shadow of the mode register, seen from the write port
	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rgbyg_pkg::MODE_GRAY;
		end else if (wr_en && wr_index == rgbyg_pkg::REG_MODE) begin
			mode_q <= wr_mode_bit;
		end
	end

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out) &&
		$stable(green_out) && $stable(blue_out))
		else $error("result word changed while stalled");

	// empty output stage means the pipe can take a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with output stage empty");

	// gray mode gives one value on all channels
	a_gray_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q == rgbyg_pkg::MODE_GRAY |->
		red_out == green_out && green_out == blue_out)
		else $error("gray result channels differ");

	// accepted word reaches result valid through the stages with no back-pressure
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing four cycles after accept");

endmodule

bind rgb_yuv_gray_and_luma_shift_top rgbyg_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pixel.valid),
	.in_ready    (pixel.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.red_out     (result.red_out),
	.green_out   (result.green_out),
	.blue_out    (result.blue_out),
	.wr_en       (wr_en),
	.wr_index    (wr_index),
	.wr_mode_bit (wr_data[0])
);
